// File: design/at_response_field_tokenizer_assert.svh
// Assertion macros shared by the checker of the AT answer-line tokenizer.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef AT_RESPONSE_FIELD_TOKENIZER_ASSERT_SVH
`define AT_RESPONSE_FIELD_TOKENIZER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AT_RFT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define AT_RFT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");

`endif

// File: design/at_rft_pkg.sv
// Package of the AT answer-line tokenizer: result record, codes and characters.
// Used by every module of the block; depends on nothing.
package at_rft_pkg;

    localparam int MAX_RESULTS = 3;
    localparam int QDEPTH      = 4;
    localparam int QIDX_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    localparam logic CFG_PREFIX_BYTES  = 1'b0;
    localparam logic CFG_PREFIX_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_DONE = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_PREFIX      = 3'd1,
        ST_STRAY_QUOTE = 3'd2,
        ST_NO_COMMA    = 3'd3,
        ST_OPEN_QUOTE  = 3'd4
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  fbyte;
        logic [7:0]  fnum;
        logic        quoted;
        t_status     status;
        logic        last;
    } t_result;

    // Results caused by one byte, in order; only the first count are meaningful.
    typedef struct packed {
        logic [1:0]                      count;
        t_result [MAX_RESULTS-1:0]       slot;
    } t_bundle;

    function automatic t_result mk_result(t_kind kind, logic [7:0] fbyte, logic [7:0] fnum,
                                          logic quoted, t_status status);
        t_result r;
        r.kind   = kind;
        r.fbyte  = fbyte;
        r.fnum   = fnum;
        r.quoted = quoted;
        r.status = status;
        r.last   = 1'b0;
        return r;
    endfunction

endpackage

// File: design/at_rft_parse.sv
// Phase machine of the tokenizer: line state registers and the per-byte decode.
// Depends on at_rft_pkg.
module at_rft_parse #(
    parameter int MAX_PREFIX = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_input_byte,
    input  logic                i_end_of_line,
    input  logic [63:0]         i_prefix_bytes,
    input  logic [3:0]          i_prefix_length,
    output at_rft_pkg::t_bundle o_bundle
);

    localparam int PW = $clog2(MAX_PREFIX + 1);

    typedef enum logic [2:0] {
        PH_LEAD, PH_PREFIX, PH_SPACES, PH_FSTART,
        PH_UNQUOTED, PH_QUOTED, PH_AFTERQ, PH_ERROR
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [PW-1:0]       r_pos, n_pos;
    logic [7:0]          r_field, n_field;
    at_rft_pkg::t_status r_err, n_err;
    logic                r_saw, n_saw;

    always_comb begin
        logic [3:0] len;
        logic [3:0] pos4;
        logic [7:0] pchar;
        logic [1:0] k;
        logic       ws;
        t_phase     ph;
        at_rft_pkg::t_bundle bnd;

        len   = (i_prefix_length > 4'(MAX_PREFIX)) ? 4'(MAX_PREFIX) : i_prefix_length;
        pos4  = 4'(r_pos);
        pchar = i_prefix_bytes[{pos4[2:0], 3'b000} +: 8];
        ws    = i_input_byte inside {at_rft_pkg::CH_SPACE, [8'd9:8'd13]};

        n_pos   = r_pos;
        n_field = r_field;
        n_err   = r_err;
        n_saw   = r_saw;
        bnd     = '0;
        k       = 2'd0;

        // Resolve the phase changes that pass the byte on without using it.
        ph = r_phase;
        if (ph == PH_LEAD && !ws) begin
            ph = (len == 4'd0) ? PH_SPACES : PH_PREFIX;
        end
        if (ph == PH_PREFIX && pos4 >= len) begin
            ph = PH_SPACES;
        end
        if (ph == PH_SPACES && i_input_byte != at_rft_pkg::CH_SPACE) begin
            ph = PH_FSTART;
        end

        case (ph)
            PH_PREFIX: begin
                if (i_input_byte != pchar) begin
                    n_err = at_rft_pkg::ST_PREFIX;
                    ph    = PH_ERROR;
                end else begin
                    n_pos = PW'(pos4 + 4'd1);
                    if (pos4 + 4'd1 >= len) begin
                        ph = PH_SPACES;
                    end
                end
            end
            PH_FSTART: begin
                n_saw = 1'b1;
                if (i_input_byte == at_rft_pkg::CH_COMMA) begin
                    bnd.slot[k] = at_rft_pkg::mk_result(at_rft_pkg::KIND_END, 8'd0, n_field,
                                                        1'b0, at_rft_pkg::ST_OK);
                    k = k + 2'd1;
                    if (n_field != 8'hFF) n_field = n_field + 8'd1;
                end else if (i_input_byte == at_rft_pkg::CH_QUOTE) begin
                    ph = PH_QUOTED;
                end else begin
                    bnd.slot[k] = at_rft_pkg::mk_result(at_rft_pkg::KIND_BYTE, i_input_byte,
                                                        n_field, 1'b0, at_rft_pkg::ST_OK);
                    k  = k + 2'd1;
                    ph = PH_UNQUOTED;
                end
            end
            PH_UNQUOTED: begin
                if (i_input_byte == at_rft_pkg::CH_COMMA) begin
                    bnd.slot[k] = at_rft_pkg::mk_result(at_rft_pkg::KIND_END, 8'd0, n_field,
                                                        1'b0, at_rft_pkg::ST_OK);
                    k  = k + 2'd1;
                    if (n_field != 8'hFF) n_field = n_field + 8'd1;
                    ph = PH_FSTART;
                end else if (i_input_byte == at_rft_pkg::CH_QUOTE) begin
                    n_err = at_rft_pkg::ST_STRAY_QUOTE;
                    ph    = PH_ERROR;
                end else begin
                    bnd.slot[k] = at_rft_pkg::mk_result(at_rft_pkg::KIND_BYTE, i_input_byte,
                                                        n_field, 1'b0, at_rft_pkg::ST_OK);
                    k = k + 2'd1;
                end
            end
            PH_QUOTED: begin
                if (i_input_byte == at_rft_pkg::CH_QUOTE) begin
                    ph = PH_AFTERQ;
                end else begin
                    bnd.slot[k] = at_rft_pkg::mk_result(at_rft_pkg::KIND_BYTE, i_input_byte,
                                                        n_field, 1'b1, at_rft_pkg::ST_OK);
                    k = k + 2'd1;
                end
            end
            PH_AFTERQ: begin
                if (i_input_byte == at_rft_pkg::CH_COMMA) begin
                    bnd.slot[k] = at_rft_pkg::mk_result(at_rft_pkg::KIND_END, 8'd0, n_field,
                                                        1'b1, at_rft_pkg::ST_OK);
                    k  = k + 2'd1;
                    if (n_field != 8'hFF) n_field = n_field + 8'd1;
                    ph = PH_FSTART;
                end else if (i_input_byte == at_rft_pkg::CH_QUOTE) begin
                    n_err = at_rft_pkg::ST_STRAY_QUOTE;
                    ph    = PH_ERROR;
                end else begin
                    n_err = at_rft_pkg::ST_NO_COMMA;
                    ph    = PH_ERROR;
                end
            end
            default: begin
            end
        endcase

        if (i_end_of_line) begin
            case (ph)
                PH_LEAD: begin
                    if (len != 4'd0) begin
                        n_err = at_rft_pkg::ST_PREFIX;
                        ph    = PH_ERROR;
                    end
                end
                PH_PREFIX: begin
                    if (4'(n_pos) < len) begin
                        n_err = at_rft_pkg::ST_PREFIX;
                        ph    = PH_ERROR;
                    end
                end
                PH_FSTART, PH_UNQUOTED, PH_AFTERQ: begin
                    if (ph != PH_FSTART || n_saw) begin
                        bnd.slot[k] = at_rft_pkg::mk_result(at_rft_pkg::KIND_END, 8'd0,
                                                            n_field, ph == PH_AFTERQ,
                                                            at_rft_pkg::ST_OK);
                        k = k + 2'd1;
                        if (n_field != 8'hFF) n_field = n_field + 8'd1;
                    end
                end
                PH_QUOTED: begin
                    n_err = at_rft_pkg::ST_OPEN_QUOTE;
                    ph    = PH_ERROR;
                end
                default: begin
                end
            endcase
            if (k != 2'd3) begin
                bnd.slot[k] = at_rft_pkg::mk_result(at_rft_pkg::KIND_DONE, 8'd0, n_field, 1'b0,
                                  (ph == PH_ERROR) ? n_err : at_rft_pkg::ST_OK);
                k = k + 2'd1;
            end
            // Every line starts afresh.
            ph      = PH_LEAD;
            n_pos   = '0;
            n_field = 8'd0;
            n_err   = at_rft_pkg::ST_OK;
            n_saw   = 1'b0;
        end

        if (k != 2'd0) begin
            bnd.slot[k - 2'd1].last = 1'b1;
        end
        bnd.count = k;
        n_phase   = ph;
        o_bundle  = bnd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_pos   <= '0;
            r_field <= 8'd0;
            r_err   <= at_rft_pkg::ST_OK;
            r_saw   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_field <= n_field;
            r_err   <= n_err;
            r_saw   <= n_saw;
        end
    end

endmodule

// File: design/at_rft_outq.sv
// Result queue of the tokenizer: holds the results of accepted bytes until taken.
// Depends on at_rft_pkg.
module at_rft_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  at_rft_pkg::t_bundle i_bundle,
    output logic                o_space,
    output logic                o_valid,
    input  logic                i_ready,
    output at_rft_pkg::t_result o_head
);

    localparam int QD = at_rft_pkg::QDEPTH;
    localparam int CW = at_rft_pkg::QCNT_W;
    localparam int IW = at_rft_pkg::QIDX_W;

    at_rft_pkg::t_result r_q [QD];
    at_rft_pkg::t_result n_q [QD];
    logic [CW-1:0]       r_count, n_count;

    assign o_valid = (r_count != '0);
    assign o_head  = r_q[0];
    // Room for the most results one byte can cause.
    assign o_space = (r_count <= CW'(QD - at_rft_pkg::MAX_RESULTS));

    always_comb begin
        logic          pop;
        logic [CW-1:0] base;
        pop  = o_valid && i_ready;
        base = r_count - CW'(pop);
        for (int i = 0; i < QD; i++) begin
            n_q[i] = r_q[i];
        end
        if (pop) begin
            for (int i = 0; i < QD - 1; i++) begin
                n_q[i] = r_q[i + 1];
            end
        end
        for (int j = 0; j < at_rft_pkg::MAX_RESULTS; j++) begin
            if (i_push && j < int'(i_bundle.count)) begin
                n_q[IW'(base + CW'(j))] = i_bundle.slot[j];
            end
        end
        n_count = base + (i_push ? CW'(i_bundle.count) : CW'(0));
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QD; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

// File: design/at_response_field_tokenizer.sv
// AT answer-line field tokenizer. Bytes of a modem answer line arrive on the input
// channel, the last one flagged by i_end_of_line. The block skips leading whitespace,
// matches the configured command prefix, skips the spaces after it and splits the
// rest at commas into unquoted or quoted fields. Each input byte causes zero to three
// results: field content bytes, field ends and, on the last byte, one line-done result
// whose status is ok, prefix mismatch, stray quote, missing comma after a closing
// quote or unterminated quote; the consumer should drop any line that is not ok.
// Timing: a byte is decoded in the cycle of its transfer and its results are visible
// from the next cycle. One byte can be taken every cycle while the four-entry result
// queue holds at most one result; the output port delivers one result per cycle while
// ready, so a line whose bytes cause several results each is paced by the result side.
// The configuration port is always ready; write it only while no line is in progress.
// Depends on at_rft_pkg, at_rft_parse and at_rft_outq.
module at_response_field_tokenizer #(
    parameter int MAX_PREFIX = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // input bytes
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_input_byte,
    input  logic        i_end_of_line,
    // results
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_field_byte,
    output logic [7:0]  o_field_number,
    output logic        o_field_quoted,
    output logic [2:0]  o_line_status,
    output logic        o_last_of_run
);

    logic [63:0]         r_prefix_bytes;
    logic [3:0]          r_prefix_length;
    logic                accept;
    at_rft_pkg::t_bundle bundle;
    at_rft_pkg::t_result head;

    // Configuration registers. A write to prefix_length keeps only its low four bits;
    // lengths beyond MAX_PREFIX are clamped by the phase machine.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_bytes  <= 64'd0;
            r_prefix_length <= 4'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                at_rft_pkg::CFG_PREFIX_BYTES:  r_prefix_bytes  <= i_cfg_data;
                at_rft_pkg::CFG_PREFIX_LENGTH: r_prefix_length <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // A byte is taken whenever the queue has room for everything it could cause.
    assign accept = i_in_valid && o_in_ready;

    at_rft_parse #(
        .MAX_PREFIX(MAX_PREFIX)
    ) u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_input_byte   (i_input_byte),
        .i_end_of_line  (i_end_of_line),
        .i_prefix_bytes (r_prefix_bytes),
        .i_prefix_length(r_prefix_length),
        .o_bundle       (bundle)
    );

    at_rft_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_bundle(bundle),
        .o_space (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_head  (head)
    );

    // Each result transfer presents the head of the queue field by field.
    assign o_result_kind  = head.kind;
    assign o_field_byte   = head.fbyte;
    assign o_field_number = head.fnum;
    assign o_field_quoted = head.quoted;
    assign o_line_status  = head.status;
    assign o_last_of_run  = head.last;

endmodule

// File: design/at_rft_checker.sv
// Port-level checker for the AT answer-line tokenizer, bound to the top level.
// Depends on at_rft_pkg and at_response_field_tokenizer_assert.svh.
`include "at_response_field_tokenizer_assert.svh"

module at_rft_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_result_kind,
    input logic [7:0]  o_field_byte,
    input logic [2:0]  o_line_status,
    input logic        o_last_of_run
);

    `AT_RFT_ASSERT_NEXT(a_out_held, o_out_valid && !i_out_ready, o_out_valid)

    `AT_RFT_ASSERT_NOW(a_kind_known, o_out_valid, o_result_kind == at_rft_pkg::KIND_BYTE || o_result_kind == at_rft_pkg::KIND_END || o_result_kind == at_rft_pkg::KIND_DONE)

    `AT_RFT_ASSERT_NOW(a_byte_zero, o_out_valid && o_result_kind != at_rft_pkg::KIND_BYTE, o_field_byte == 8'd0)

    `AT_RFT_ASSERT_NOW(a_done_last, o_out_valid && o_result_kind == at_rft_pkg::KIND_DONE, o_last_of_run)

    `AT_RFT_ASSERT_NOW(a_status_done, o_out_valid && o_result_kind != at_rft_pkg::KIND_DONE, o_line_status == at_rft_pkg::ST_OK)

endmodule

bind at_response_field_tokenizer at_rft_checker u_at_rft_checker (.*);

// File: tb/sv/at_rft_token_checker.sv
// Checker for the AT answer-line tokenizer: watches the configuration, byte and result
// channels, predicts the results of every byte and compares them in order.
// Depends on at_rft_pkg for the result record, codes and characters.
module at_rft_token_checker #(
    parameter int PREFIX_LIMIT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_input_byte,
    input  logic        i_end_of_line,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_result_kind,
    input  logic [7:0]  i_field_byte,
    input  logic [7:0]  i_field_number,
    input  logic        i_field_quoted,
    input  logic [2:0]  i_line_status,
    input  logic        i_last_of_run,
    output int          o_mismatches,
    output int          o_outstanding
);
    import at_rft_pkg::*;

    typedef enum logic [2:0] {
        SCAN_LEAD,
        SCAN_PREFIX,
        SCAN_SPACES,
        FIELD_START,
        IN_UNQUOTED,
        IN_QUOTED,
        AFTER_QUOTE,
        LINE_FAILED
    } t_scan;

    logic [63:0] prefix_chars;
    logic [3:0]  prefix_len;

    t_scan       scan;
    logic [3:0]  prefix_pos;
    logic [7:0]  field_idx;
    t_status     err_status;
    logic        seen_field;

    t_result     run_buf [MAX_RESULTS];
    int          run_len;
    t_result     expected_q [$];
    int          mismatches;

    task automatic start_line();
        scan       = SCAN_LEAD;
        prefix_pos = '0;
        field_idx  = '0;
        err_status = ST_OK;
        seen_field = 1'b0;
    endtask

    task automatic emit(input t_kind kind, input logic [7:0] fb, input logic q,
                        input t_status st);
        if (run_len < MAX_RESULTS) begin
            run_buf[run_len].kind   = kind;
            run_buf[run_len].fbyte  = fb;
            run_buf[run_len].fnum   = field_idx;
            run_buf[run_len].quoted = q;
            run_buf[run_len].status = st;
            run_buf[run_len].last   = 1'b0;
            run_len++;
        end
    endtask

    task automatic end_field(input logic q);
        emit(KIND_END, 8'd0, q, ST_OK);
        if (field_idx != 8'd255) begin
            field_idx++;
        end
    endtask

    task automatic line_fails(input t_status st);
        err_status = st;
        scan       = LINE_FAILED;
    endtask

    // Works out the results of one byte and queues them in order.
    task automatic tokenize_byte(input logic [7:0] b, input logic eol);
        logic [3:0] eff_len;
        bit         again;
        eff_len = (prefix_len > PREFIX_LIMIT) ? 4'(PREFIX_LIMIT) : prefix_len;
        run_len = 0;
        again   = 1'b1;
        while (again) begin
            again = 1'b0;
            case (scan)
                SCAN_LEAD: begin
                    if (!(b == CH_SPACE || (b >= 8'd9 && b <= 8'd13))) begin
                        scan  = (eff_len == 0) ? SCAN_SPACES : SCAN_PREFIX;
                        again = 1'b1;
                    end
                end
                SCAN_PREFIX: begin
                    if (prefix_pos >= eff_len) begin
                        scan  = SCAN_SPACES;
                        again = 1'b1;
                    end else if (b != prefix_chars[prefix_pos[2:0] * 8 +: 8]) begin
                        line_fails(ST_PREFIX);
                    end else begin
                        prefix_pos++;
                        if (prefix_pos >= eff_len) begin
                            scan = SCAN_SPACES;
                        end
                    end
                end
                SCAN_SPACES: begin
                    if (b != CH_SPACE) begin
                        scan  = FIELD_START;
                        again = 1'b1;
                    end
                end
                FIELD_START: begin
                    seen_field = 1'b1;
                    if (b == CH_COMMA) begin
                        end_field(1'b0);
                    end else if (b == CH_QUOTE) begin
                        scan = IN_QUOTED;
                    end else begin
                        emit(KIND_BYTE, b, 1'b0, ST_OK);
                        scan = IN_UNQUOTED;
                    end
                end
                IN_UNQUOTED: begin
                    if (b == CH_COMMA) begin
                        end_field(1'b0);
                        scan = FIELD_START;
                    end else if (b == CH_QUOTE) begin
                        line_fails(ST_STRAY_QUOTE);
                    end else begin
                        emit(KIND_BYTE, b, 1'b0, ST_OK);
                    end
                end
                IN_QUOTED: begin
                    if (b == CH_QUOTE) begin
                        scan = AFTER_QUOTE;
                    end else begin
                        emit(KIND_BYTE, b, 1'b1, ST_OK);
                    end
                end
                AFTER_QUOTE: begin
                    if (b == CH_COMMA) begin
                        end_field(1'b1);
                        scan = FIELD_START;
                    end else if (b == CH_QUOTE) begin
                        line_fails(ST_STRAY_QUOTE);
                    end else begin
                        line_fails(ST_NO_COMMA);
                    end
                end
                default: ;
            endcase
        end

        if (eol) begin
            case (scan)
                SCAN_LEAD:   if (eff_len != 0) line_fails(ST_PREFIX);
                SCAN_PREFIX: if (prefix_pos < eff_len) line_fails(ST_PREFIX);
                FIELD_START: if (seen_field) end_field(1'b0);
                IN_UNQUOTED: end_field(1'b0);
                IN_QUOTED:   line_fails(ST_OPEN_QUOTE);
                AFTER_QUOTE: end_field(1'b1);
                default: ;
            endcase
            emit(KIND_DONE, 8'd0, 1'b0, (scan == LINE_FAILED) ? err_status : ST_OK);
            start_line();
        end

        if (run_len > 0) begin
            run_buf[run_len - 1].last = 1'b1;
        end
        for (int i = 0; i < run_len; i++) begin
            expected_q.push_back(run_buf[i]);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            prefix_chars = '0;
            prefix_len   = '0;
            start_line();
            expected_q.delete();
            mismatches   = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PREFIX_BYTES:  prefix_chars = i_cfg_data;
                    CFG_PREFIX_LENGTH: prefix_len   = i_cfg_data[3:0];
                    default: ;
                endcase
            end

            // Results already waiting belong to earlier bytes, so compare first.
            if (i_out_valid && i_out_ready) begin
                got.kind   = t_kind'(i_result_kind);
                got.fbyte  = i_field_byte;
                got.fnum   = i_field_number;
                got.quoted = i_field_quoted;
                got.status = t_status'(i_line_status);
                got.last   = i_last_of_run;
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: kind=%0d byte=%02h num=%0d quoted=%0d",
                                 got.kind, got.fbyte, got.fnum, got.quoted);
                    end
                end else begin
                    want = expected_q.pop_front();
                    if (got.kind !== want.kind || got.fbyte !== want.fbyte ||
                        got.fnum !== want.fnum || got.quoted !== want.quoted ||
                        got.status !== want.status || got.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result mismatch: expected kind=%0d byte=%02h num=%0d",
                                     want.kind, want.fbyte, want.fnum,
                                     " quoted=%0d status=%0d last=%0d",
                                     want.quoted, want.status, want.last);
                            $display("                 got      kind=%0d byte=%02h num=%0d",
                                     got.kind, got.fbyte, got.fnum,
                                     " quoted=%0d status=%0d last=%0d",
                                     got.quoted, got.status, got.last);
                        end
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                tokenize_byte(i_input_byte, i_end_of_line);
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= expected_q.size();
    end

endmodule

// File: tb/sv/tb_at_response_field_tokenizer.sv
// Testbench top of the AT answer-line tokenizer: clock, reset, byte and configuration
// stimulus, result back-pressure and the verdict.
// Depends on at_rft_pkg, the block itself and at_rft_token_checker.
module tb_at_response_field_tokenizer;
    import at_rft_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_input_byte;
    logic        i_end_of_line;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_result_kind;
    logic [7:0]  o_field_byte;
    logic [7:0]  o_field_number;
    logic        o_field_quoted;
    logic [2:0]  o_line_status;
    logic        o_last_of_run;

    int mismatches;
    int outstanding;

    // Percentage of cycles in which each side holds back.
    int sender_idle_pct;
    int receiver_idle_pct;

    // The prefix as last written, used only to build the random lines.
    logic [63:0] prefix_now;
    logic [3:0]  length_now;

    logic [7:0]  line_buf [$];

    logic [7:0]  blank_chars [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

    // Prefix settings visited by the random part: a short typical prefix, all ones
    // with a length past the limit, the empty prefix, a full eight-character prefix,
    // a random prefix and a prefix of NUL characters.
    logic [63:0] setting_chars [6] = '{64'h0000_003A_5153_432B, 64'hFFFF_FFFF_FFFF_FFFF,
                                       64'd0, 64'h203A_4745_5247_432B, 64'd0, 64'd0};
    logic [3:0]  setting_count [6] = '{4'd5, 4'd15, 4'd0, 4'd8, 4'd4, 4'd3};

    at_response_field_tokenizer uut (.*);

    at_rft_token_checker token_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_input_byte   (i_input_byte),
        .i_end_of_line  (i_end_of_line),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_result_kind  (o_result_kind),
        .i_field_byte   (o_field_byte),
        .i_field_number (o_field_number),
        .i_field_quoted (o_field_quoted),
        .i_line_status  (o_line_status),
        .i_last_of_run  (o_last_of_run),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The result side stalls at random; a fresh decision is taken every cycle so that
    // stalls land on every phase of the block's work.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("at_response_field_tokenizer regression: fail");
        $finish;
    end

    // Offers one byte and holds it until the transfer. Valid is only lowered while the
    // sender idles, so back-to-back bytes keep valid high across the edge.
    task automatic send_byte(input logic [7:0] b, input logic eol);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_input_byte  <= b;
        i_end_of_line <= eol;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++) begin
            send_byte(line_buf[i], i == line_buf.size() - 1);
        end
    endtask

    task automatic send_text(input string s);
        line_buf.delete();
        for (int i = 0; i < s.len(); i++) begin
            line_buf.push_back(s[i]);
        end
        send_line();
    endtask

    // Stops offering bytes and waits until the checker holds no expectation.
    // The count seen at an edge reflects the edge before, so the clock advances before each check.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // Both registers are written only between lines with the block drained; the extra
    // cycles cover bytes that raised no result but may still be in flight.
    task automatic write_config(input logic [63:0] chars, input logic [3:0] count);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_PREFIX_BYTES;
        i_cfg_data  <= chars;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_PREFIX_LENGTH;
        i_cfg_data  <= {60'd0, count};
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        prefix_now  = chars;
        length_now  = count;
    endtask

    function automatic logic [7:0] content_byte(input bit allow_comma);
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == CH_QUOTE || (!allow_comma && c == CH_COMMA));
        return c;
    endfunction

    // Builds one answer line. Most lines are well formed with random content so that
    // they get past the prefix; some carry a damaged prefix or a broken field, and a
    // few are plain noise.
    task automatic build_random_line();
        int  shape;
        int  eff;
        int  cut;
        int  style;
        int  flen;
        bit  truncated;
        line_buf.delete();
        eff       = (length_now > 8) ? 8 : length_now;
        shape     = $urandom_range(0, 9);
        truncated = 1'b0;
        if (shape == 0) begin
            repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 2)) line_buf.push_back(blank_chars[$urandom_range(0, 5)]);
            cut = (eff > 0) ? $urandom_range(0, eff - 1) : 0;
            for (int i = 0; i < eff && !truncated; i++) begin
                if (shape == 1 && i == cut) begin
                    // Damaged prefix: either the line stops early or one character is wrong.
                    if ($urandom_range(0, 1) == 0) begin
                        truncated = 1'b1;
                    end else begin
                        line_buf.push_back(prefix_now[i * 8 +: 8] ^ 8'($urandom_range(1, 255)));
                    end
                end else begin
                    line_buf.push_back(prefix_now[i * 8 +: 8]);
                end
            end
            if (!truncated) begin
                repeat ($urandom_range(0, 2)) line_buf.push_back(CH_SPACE);
                for (int f = $urandom_range(0, 4); f > 0; f--) begin
                    style = $urandom_range(0, 10);
                    flen  = $urandom_range(0, 3);
                    if (style < 5) begin
                        repeat (flen) line_buf.push_back(content_byte(1'b0));
                    end else if (style < 10) begin
                        line_buf.push_back(CH_QUOTE);
                        repeat (flen) line_buf.push_back(content_byte(1'b1));
                        line_buf.push_back(CH_QUOTE);
                    end else begin
                        case ($urandom_range(0, 3))
                            0: begin
                                // Quote inside an unquoted field.
                                line_buf.push_back(content_byte(1'b0));
                                line_buf.push_back(CH_QUOTE);
                            end
                            1: begin
                                // Some other character right after the closing quote.
                                line_buf.push_back(CH_QUOTE);
                                line_buf.push_back(CH_QUOTE);
                                line_buf.push_back(content_byte(1'b0));
                            end
                            2: begin
                                // A second quote right after the closing quote.
                                line_buf.push_back(CH_QUOTE);
                                line_buf.push_back(content_byte(1'b1));
                                line_buf.push_back(CH_QUOTE);
                                line_buf.push_back(CH_QUOTE);
                            end
                            default: begin
                                // An opening quote that may never be closed.
                                line_buf.push_back(CH_QUOTE);
                                repeat (flen) line_buf.push_back(content_byte(1'b0));
                            end
                        endcase
                    end
                    if (f > 1) begin
                        line_buf.push_back(CH_COMMA);
                    end
                end
                if ($urandom_range(0, 5) == 0) begin
                    line_buf.push_back(CH_COMMA);
                end
            end
        end
        if (line_buf.size() == 0) begin
            line_buf.push_back(CH_SPACE);
        end
    endtask

    initial begin
        int sent;
        i_rst_n           = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = CFG_PREFIX_BYTES;
        i_cfg_data        = '0;
        i_in_valid        = 1'b0;
        i_input_byte      = '0;
        i_end_of_line     = 1'b0;
        i_out_ready       = 1'b0;
        sender_idle_pct   = 15;
        receiver_idle_pct = 63;
        prefix_now        = '0;
        length_now        = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed lines with the empty prefix left by reset.
        send_text("\ta,\"b\"");      // leading whitespace, an unquoted and a quoted field
        send_text("\"\",,");         // empty quoted string, empty field, trailing comma
        send_text("a\"x");           // stray quote in an unquoted field, rest ignored
        send_text("\"a\"\"");        // quote straight after the closing quote
        send_text("\"a\"b");         // no comma after the closing quote
        send_text("\"a");            // line ends inside quotes
        send_text("\377");           // top byte value as a one-byte field
        send_text(" ");              // whitespace only: ok with no fields

        write_config(64'h5441, 4'd2);
        send_text("A");              // line ends before the prefix is complete
        send_text("AT ");            // nothing after the prefix and its spaces

        // Random part in three rounds of idling: sender light and receiver heavy, then
        // the other way round, then no idling at all. Each round visits two settings.
        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct   = (phase == 0) ? 15 : (phase == 1) ? 63 : 0;
            receiver_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 15 : 0;
            for (int s = 2 * phase; s < 2 * phase + 2; s++) begin
                if (s == 4) begin
                    setting_chars[s] = {$urandom, $urandom};
                    setting_count[s] = 4'($urandom_range(1, 8));
                end
                write_config(setting_chars[s], setting_count[s]);
                sent = 0;
                while (sent < 18) begin
                    build_random_line();
                    sent += line_buf.size();
                    send_line();
                end
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("at_response_field_tokenizer regression: pass");
        end else begin
            $display("at_response_field_tokenizer regression: fail");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/at_rft_pkg.sv
design/at_rft_parse.sv
design/at_rft_outq.sv
design/at_response_field_tokenizer.sv
design/at_rft_checker.sv
tb/sv/at_rft_token_checker.sv
tb/sv/tb_at_response_field_tokenizer.sv
